>>> hdl/ledrs_pkg.sv
// ----------------------------------------------------------------------------
// ledrs_pkg
// Shared types and constants for the LED driver refresh serialiser.
// ----------------------------------------------------------------------------
package ledrs_pkg;

    // number of digit entries in the local buffer
    localparam int DIGIT_COUNT = 6;
    localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    // host operation codes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_BRIGHT = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_WRITE  = 2'd3;

    // command bytes and address range
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] CMD_BRIGHT_BASE = 8'h88;
    localparam logic [3:0] BRIGHT_MAX      = 4'd8;
    localparam logic [7:0] GRID_BASE       = 8'hC0;
    localparam logic [7:0] GRID_TOP        = 8'(8'hC0 + 2 * DIGIT_COUNT - 1);

    // configuration register map and reset values
    localparam logic MODE_CMD_SEL = 1'b0;
    localparam logic DATA_CMD_SEL = 1'b1;
    localparam logic [7:0] MODE_CMD_RESET = 8'h03;
    localparam logic [7:0] DATA_CMD_RESET = 8'h44;

    // job queue between the front and back ends
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // kind of serial job: sets byte count and frame marking
    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_BRIGHT,
        JOB_REFRESH
    } t_job_kind;

    // one queued job: up to four bytes, byte 0 in the low bits
    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] data;
    } t_job;

endpackage

>>> hdl/ledrs_front.sv
// ----------------------------------------------------------------------------
// ledrs_front
// Accepts host transactions, keeps the digit buffer and refresh address,
// and turns each init, brightness or refresh command into a queued serial job.
// ----------------------------------------------------------------------------
module ledrs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_op,
    input  logic [2:0]           i_digit_index,
    input  logic [7:0]           i_digit_value,
    input  logic [3:0]           i_brightness,
    input  logic [7:0]           i_mode_cmd,
    input  logic [7:0]           i_data_cmd,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output ledrs_pkg::t_job      o_job
);
    import ledrs_pkg::*;

    logic [7:0] r_digit [DIGIT_COUNT];
    logic [7:0] r_grid;
    logic [2:0] r_ptr;

    logic       accept;
    logic [7:0] grid_step;
    logic [7:0] grid_second;
    logic [2:0] ptr_step;
    logic [7:0] digit_byte;
    logic [7:0] digit_remap;
    logic [3:0] level;
    logic [7:0] bright_cmd;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // refresh address and pointer step
    always_comb begin
        if (r_grid > GRID_BASE) begin
            grid_step = r_grid - 8'd1;
            ptr_step  = r_ptr + 3'd1;
        end else begin
            grid_step = GRID_TOP;
            ptr_step  = 3'd0;
        end
        grid_second = grid_step - 8'd1;
        if ({1'b0, ptr_step} < 4'(DIGIT_COUNT)) begin
            digit_byte = r_digit[ptr_step[IDX_W-1:0]];
        end else begin
            digit_byte = 8'd0;
        end
        digit_remap = {digit_byte[5:0], digit_byte[1:0]};
    end

    // brightness command with saturation
    always_comb begin
        level = (i_brightness > BRIGHT_MAX) ? BRIGHT_MAX : i_brightness;
        if (level == 4'd0) begin
            bright_cmd = CMD_DISPLAY_OFF;
        end else begin
            bright_cmd = CMD_BRIGHT_BASE | {4'd0, level - 4'd1};
        end
    end

    // job build
    always_comb begin
        o_push     = 1'b0;
        o_job.kind = JOB_INIT;
        o_job.data = 32'd0;
        unique case (i_op)
            OP_INIT: begin
                o_push     = accept;
                o_job.kind = JOB_INIT;
                o_job.data = {16'd0, i_data_cmd, i_mode_cmd};
            end
            OP_BRIGHT: begin
                o_push     = accept;
                o_job.kind = JOB_BRIGHT;
                o_job.data = {24'd0, bright_cmd};
            end
            OP_REFRESH: begin
                o_push     = accept;
                o_job.kind = JOB_REFRESH;
                o_job.data = {digit_byte, grid_second, digit_remap, grid_step};
            end
            OP_WRITE: begin
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // buffer and refresh state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_digit[i] <= 8'd0;
            end
            r_grid <= 8'd0;
            r_ptr  <= 3'd0;
        end else if (accept) begin
            if (i_op == OP_REFRESH) begin
                r_grid <= grid_second;
                r_ptr  <= ptr_step;
            end else if (i_op == OP_WRITE &&
                         {1'b0, i_digit_index} < 4'(DIGIT_COUNT)) begin
                r_digit[i_digit_index[IDX_W-1:0]] <= i_digit_value;
            end
        end
    end

endmodule

>>> hdl/ledrs_queue.sv
// ----------------------------------------------------------------------------
// ledrs_queue
// Short job queue that decouples the front end from the serialiser.
// ----------------------------------------------------------------------------
module ledrs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ledrs_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output ledrs_pkg::t_job o_job
);
    import ledrs_pkg::*;

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_entry[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/ledrs_back.sv
// ----------------------------------------------------------------------------
// ledrs_back
// Serialiser: shifts queued jobs out LSB first with frame marks, one bit
// per output transaction, through a registered output stage.
// ----------------------------------------------------------------------------
module ledrs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  ledrs_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_dio,
    output logic            o_frame_start,
    output logic            o_frame_end,
    output logic            o_last
);
    import ledrs_pkg::*;

    logic        r_active;
    t_job_kind   r_kind;
    logic [31:0] r_data;
    logic [1:0]  r_byte;
    logic [2:0]  r_bit;

    logic        r_valid;
    logic        r_dio;
    logic        r_frame_start;
    logic        r_frame_end;
    logic        r_last;

    logic        advance;
    logic        emit;
    t_job_kind   src_kind;
    logic [31:0] src_data;
    logic [1:0]  byte_i;
    logic [2:0]  bit_i;
    logic [1:0]  last_byte;
    logic        bit_dio;
    logic        bit_start;
    logic        bit_end;
    logic        bit_last;

    assign advance = !r_valid || !i_stall;
    assign emit    = advance && (r_active || i_job_valid);
    assign o_pop   = emit && !r_active;

    // select the bit source: running job or head of the queue
    always_comb begin
        src_kind = r_active ? r_kind : i_job.kind;
        src_data = r_active ? r_data : i_job.data;
        byte_i   = r_active ? r_byte : 2'd0;
        bit_i    = r_active ? r_bit  : 3'd0;
        unique case (src_kind)
            JOB_INIT:    last_byte = 2'd1;
            JOB_BRIGHT:  last_byte = 2'd0;
            JOB_REFRESH: last_byte = 2'd3;
            default:     last_byte = 2'd0;
        endcase
        bit_dio   = src_data[{byte_i, bit_i}];
        bit_start = (bit_i == 3'd0) && (src_kind != JOB_REFRESH || !byte_i[0]);
        bit_end   = (bit_i == 3'd7) && (src_kind != JOB_REFRESH || byte_i[0]);
        bit_last  = (bit_i == 3'd7) && (byte_i == last_byte);
    end

    // job progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_byte   <= 2'd0;
            r_bit    <= 3'd0;
        end else if (emit) begin
            r_active        <= !bit_last;
            {r_byte, r_bit} <= bit_last ? 5'd0 : {byte_i, bit_i} + 5'd1;
        end
    end

    // job payload capture on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_job.kind;
            r_data <= i_job.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_dio         <= bit_dio;
            r_frame_start <= bit_start;
            r_frame_end   <= bit_end;
            r_last        <= bit_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_dio         = r_dio;
    assign o_frame_start = r_frame_start;
    assign o_frame_end   = r_frame_end;
    assign o_last        = r_last;

endmodule

>>> hdl/led_driver_refresh_serializer.sv
// Path: an accepted command goes to the job queue; the serialiser registers its bits.
// Throughput: the serialiser sends one bit per cycle while i_stall is low, so init
// sends 16 bits, brightness 8 and refresh 32; a buffer write sends nothing.
// A two-entry job queue lets commands be accepted while the serialiser shifts.
// Reset (synchronous, active low) clears the digit buffer, refresh address and
// pointer, empties the queue and restores the command registers to 0x03 / 0x44.
// ----------------------------------------------------------------------------
// led_driver_refresh_serializer
// Serial refresh engine for a three-wire LED display controller.
// ----------------------------------------------------------------------------
module led_driver_refresh_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_digit_index,
    input  logic [7:0]  i_digit_value,
    input  logic [3:0]  i_brightness,
    // serial bit channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_dio,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ledrs_pkg::*;

    logic [7:0] r_mode_cmd;
    logic [7:0] r_data_cmd;

    logic       cfg_write;
    logic       queue_full;
    logic       queue_push;
    logic       queue_pop;
    logic       queue_nonempty;
    t_job       front_job;
    t_job       head_job;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cmd <= MODE_CMD_RESET;
            r_data_cmd <= DATA_CMD_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                MODE_CMD_SEL: r_mode_cmd <= pwdata[7:0];
                DATA_CMD_SEL: r_data_cmd <= pwdata[7:0];
                default:      r_mode_cmd <= r_mode_cmd;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            MODE_CMD_SEL: prdata = {24'd0, r_mode_cmd};
            DATA_CMD_SEL: prdata = {24'd0, r_data_cmd};
            default:      prdata = 32'd0;
        endcase
    end

    // command decode
    ledrs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_digit_index (i_digit_index),
        .i_digit_value (i_digit_value),
        .i_brightness  (i_brightness),
        .i_mode_cmd    (r_mode_cmd),
        .i_data_cmd    (r_data_cmd),
        .i_queue_full  (queue_full),
        .o_push        (queue_push),
        .o_job         (front_job)
    );

    // job queue
    ledrs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (queue_push),
        .i_job      (front_job),
        .o_full     (queue_full),
        .i_pop      (queue_pop),
        .o_nonempty (queue_nonempty),
        .o_job      (head_job)
    );

    // serialiser
    ledrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (queue_nonempty),
        .i_job         (head_job),
        .o_pop         (queue_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dio         (o_dio),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

endmodule
